// ----- hdl/binary_to_decimal_ascii_unit_macros.svh -----
// Assertion macros for the checker file of the decimal ASCII unit.
`ifndef BINARY_TO_DECIMAL_ASCII_UNIT_MACROS_SVH
`define BINARY_TO_DECIMAL_ASCII_UNIT_MACROS_SVH

// Assert a property on clk, skipped while rst_n is low.
`define BDAU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assert a property on clk that must also hold around reset.
`define BDAU_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/bdau_pkg.sv -----
// Package with constants, tables and types of the decimal ASCII unit.
package bdau_pkg;

  localparam int VALUE_W = 32;
  localparam int WIDE_W  = 36;
  localparam int DIGITS  = 10;
  localparam int DIGIT_W = 4;
  localparam int POS_W   = 4;
  localparam int CHAR_W  = 6;

  localparam logic [CHAR_W-1:0]  ASCII_ZERO = 6'd48;
  localparam logic [POS_W-1:0]   LAST_POS   = 4'd9;

  typedef logic [WIDE_W-1:0] wide_t;

  // Powers of ten, most significant digit first.
  localparam wide_t POW_TEN [DIGITS] = '{
    36'd1000000000, 36'd100000000, 36'd10000000, 36'd1000000, 36'd100000,
    36'd10000, 36'd1000, 36'd100, 36'd10, 36'd1
  };

  typedef logic [DIGITS-1:0][DIGIT_W-1:0] digit_vec_t;

  // One pipeline stage: remainder, digits found so far, first shown digit.
  typedef struct packed {
    logic [VALUE_W-1:0] rest;
    digit_vec_t         digits;
    logic [POS_W-1:0]   first;
    logic               started;
  } stage_t;

  // Converted number handed to the serializer.
  typedef struct packed {
    digit_vec_t       digits;
    logic [POS_W-1:0] first;
  } ser_load_t;

  // k times the power of ten at a digit position.
  function automatic wide_t mult_of(input int pos, input int k);
    mult_of = POW_TEN[pos] * WIDE_W'(k);
  endfunction

endpackage

// ----- hdl/bdau_serializer.sv -----
// Character serializer: emits one converted number as a run of ASCII digits.
module bdau_serializer (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               load_valid,
  input  bdau_pkg::ser_load_t                load,
  output logic                               load_ready,
  output logic                               out_strobe,
  output logic [bdau_pkg::CHAR_W-1:0]        out_digit_char,
  output logic                               out_last_digit
);

  logic                               active_r, active_nxt;
  logic [bdau_pkg::POS_W-1:0]         pos_r, pos_nxt;
  bdau_pkg::digit_vec_t               digits_r, digits_nxt;
  logic                               take;

  // Free when idle or on the units digit of the current run.
  assign load_ready = !active_r || (pos_r == bdau_pkg::LAST_POS);
  assign take       = load_valid && load_ready;

  // Load a new run or advance to the next digit.
  always_comb begin
    active_nxt = active_r;
    pos_nxt    = pos_r;
    digits_nxt = digits_r;
    if (take) begin
      active_nxt = 1'b1;
      pos_nxt    = load.first;
      digits_nxt = load.digits;
    end else if (active_r) begin
      active_nxt = (pos_r != bdau_pkg::LAST_POS);
      pos_nxt    = pos_r + bdau_pkg::POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
    end
    pos_r    <= pos_nxt;
    digits_r <= digits_nxt;
  end

  // Drive one character beat per cycle.
  assign out_strobe     = active_r;
  assign out_digit_char = bdau_pkg::ASCII_ZERO + {2'b00, digits_r[pos_r]};
  assign out_last_digit = active_r && (pos_r == bdau_pkg::LAST_POS);

endmodule

// ----- hdl/binary_to_decimal_ascii_unit.sv -----
// Top level: 32-bit binary to decimal ASCII converter.
// Pulse start with in_value while busy is low; the number enters a pipeline of eleven
// registers, ten of which each resolve one decimal digit (10^9 first) by comparing the
// remainder against the nine multiples of that power of ten. Once the beat is accepted and
// has passed these registers (later while the serializer still sends earlier runs), the
// serializer emits the digits, most significant first, one per cycle on out_strobe, without
// leading zeros; the units digit is always sent and carries out_last_digit. A run is 1 to 10
// beats and cannot be held off by the receiver. The serializer sets the sustained rate: it
// takes a new item only when idle or on the units digit of the current run, and the pipeline
// buffers up to eleven waiting items meanwhile; busy rises only when the first pipeline
// register cannot move on.
module binary_to_decimal_ascii_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [bdau_pkg::VALUE_W-1:0]       in_value,
  output logic                               out_strobe,
  output logic [bdau_pkg::CHAR_W-1:0]        out_digit_char,
  output logic                               out_last_digit
);

  localparam int NSTG = bdau_pkg::DIGITS + 1;

  bdau_pkg::stage_t     st_r   [NSTG];
  bdau_pkg::stage_t     st_nxt [NSTG];
  logic [NSTG-1:0]      v_r;
  logic [NSTG:0]        free;
  logic                 ser_ready;
  bdau_pkg::ser_load_t  ser_load;

  // Stall chain: a stage may load when it is empty or its item moves on.
  always_comb begin
    free[NSTG] = ser_ready;
    for (int i = NSTG - 1; i >= 0; i--) begin
      free[i] = !v_r[i] || free[i+1];
    end
  end

  assign busy = !free[0];

  // Capture the input beat.
  always_comb begin
    st_nxt[0].rest    = in_value;
    st_nxt[0].digits  = '0;
    st_nxt[0].first   = bdau_pkg::LAST_POS;
    st_nxt[0].started = 1'b0;
  end

  // Resolve one digit per stage.
  for (genvar g = 0; g < bdau_pkg::DIGITS; g++) begin : g_digit
    always_comb begin
      bdau_pkg::wide_t             wide;
      bdau_pkg::wide_t             sub;
      logic [bdau_pkg::DIGIT_W-1:0] dig;
      wide = {4'b0000, st_r[g].rest};
      sub  = '0;
      dig  = '0;
      for (int k = 1; k < 10; k++) begin
        if (wide >= bdau_pkg::mult_of(g, k)) begin
          dig = bdau_pkg::DIGIT_W'(k);
          sub = bdau_pkg::mult_of(g, k);
        end
      end
      st_nxt[g+1]           = st_r[g];
      st_nxt[g+1].rest      = st_r[g].rest - sub[bdau_pkg::VALUE_W-1:0];
      st_nxt[g+1].digits[g] = dig;
      if (!st_r[g].started && (dig != '0)) begin
        st_nxt[g+1].started = 1'b1;
        st_nxt[g+1].first   = bdau_pkg::POS_W'(g);
      end
    end
  end

  // Advance stages that are free; hold the rest.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (free[0]) begin
        v_r[0] <= start;
      end
      for (int i = 1; i < NSTG; i++) begin
        if (free[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
    for (int i = 0; i < NSTG; i++) begin
      if (free[i]) begin
        st_r[i] <= st_nxt[i];
      end
    end
  end

  assign ser_load.digits = st_r[NSTG-1].digits;
  assign ser_load.first  = st_r[NSTG-1].first;

  bdau_serializer u_ser (
    .clk            (clk),
    .rst_n          (rst_n),
    .load_valid     (v_r[NSTG-1]),
    .load           (ser_load),
    .load_ready     (ser_ready),
    .out_strobe     (out_strobe),
    .out_digit_char (out_digit_char),
    .out_last_digit (out_last_digit)
  );

endmodule

// ----- hdl/bdau_checker.sv -----
// Port checker for the decimal ASCII unit, bound to the top level.
`include "binary_to_decimal_ascii_unit_macros.svh"

module bdau_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [31:0] in_value,
  input logic        out_strobe,
  input logic [5:0]  out_digit_char,
  input logic        out_last_digit
);

  // Every character beat is an ASCII decimal digit.
  `BDAU_ASSERT(a_char_range, out_strobe |-> (out_digit_char >= 6'd48) && (out_digit_char <= 6'd57), "character outside '0' to '9'")

  // A run continues without gaps until its units digit.
  `BDAU_ASSERT(a_run_contiguous, out_strobe && !out_last_digit |=> out_strobe, "gap inside a digit run")

  // The opening character of a run longer than one is never a leading zero.
  `BDAU_ASSERT(a_no_leading_zero, out_strobe && !out_last_digit && !($past(out_strobe) && !$past(out_last_digit)) |-> (out_digit_char != 6'd48), "leading zero emitted")

  // Reset silences the result channel.
  `BDAU_ASSERT_RST(a_reset_quiet, !rst_n |=> !out_strobe, "result beat right after reset")

endmodule

bind binary_to_decimal_ascii_unit bdau_checker u_bdau_checker (.*);
